[design/tmf_pkg.sv]
// Shared constants and types for the message framer.
package tmf_pkg;

    localparam int unsigned LEN_W       = 28;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_W     = 7;
    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W       = 3;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic CONT_BIT = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

endpackage

[design/tts_message_framer_core.sv]
// Message framer: security byte, base-128 length prefix and payload pass-through.
//
// Input channel (in_valid/in_ready) carries one item per transaction:
//   kind = header  -> security_byte and payload_length are used
//   kind = payload -> data_byte is used
// Output channel (out_valid/out_ready) carries one framed byte per
// transaction, with last set on the final byte of a message.
//
// A header yields 2 to 5 bytes: the security byte, then the length as a
// little-endian base-128 varint with bit 7 set on all but the final byte.
// A zero length closes the message on its single 0x00 length byte.
// Payload bytes pass through one per transaction until the declared count
// is reached; payload with no open message is dropped without output.
//
// An accepted item enters the result buffer, then the output register.
// Throughput: one payload item per cycle while the receiver does not stall;
// a header holds the input while its 2 to 5 results drain from the
// five-entry result buffer, one byte per cycle, into the output register.
// Reset empties the buffer and clears the output valid flag and the message state.
// When the receiver stalls, the output register holds its byte and the
// buffer keeps its results; in_ready drops until the buffer can take a new item.
module tts_message_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  security_byte,
    input  logic [27:0] payload_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);
    import tmf_pkg::*;

    // message state
    logic [LEN_W-1:0] bytes_remaining_reg, bytes_remaining_next;
    logic             message_open_reg, message_open_next;

    // result buffer, entry 0 is the next byte to leave
    result_t          pend_reg [MAX_RESULTS];
    result_t          pend_next [MAX_RESULTS];
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic accept;
    logic pop;

    // results of the item being accepted
    result_t          load [MAX_RESULTS];
    logic [CNT_W-1:0] load_cnt;

    logic [GROUP_W-1:0] grp [4];
    logic               cont [4];
    logic               len_zero;
    logic               pay_ok;
    logic               pay_final;

    assign pop      = (pend_cnt_reg != '0) && (!out_valid_reg || out_ready);
    assign in_ready = (pend_cnt_reg == '0) ||
                      ((pend_cnt_reg == CNT_W'(1)) && pop);
    assign accept   = in_valid && in_ready;

    // split the length into 7-bit groups; a group continues when any
    // higher group is nonzero
    assign grp[0]   = payload_length[6:0];
    assign grp[1]   = payload_length[13:7];
    assign grp[2]   = payload_length[20:14];
    assign grp[3]   = payload_length[27:21];
    assign cont[0]  = (payload_length[27:7]  != '0);
    assign cont[1]  = (payload_length[27:14] != '0);
    assign cont[2]  = (payload_length[27:21] != '0);
    assign cont[3]  = 1'b0;
    assign len_zero = (payload_length == '0);

    assign pay_ok    = message_open_reg && (bytes_remaining_reg != '0);
    assign pay_final = (bytes_remaining_reg == LEN_W'(1));

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            load[i] = '0;
        end
        load_cnt             = '0;
        bytes_remaining_next = bytes_remaining_reg;
        message_open_next    = message_open_reg;

        if (kind == KIND_HEADER)
        begin
            load[0].data = security_byte;
            load[0].last = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                load[i+1].data = {(cont[i] ? CONT_BIT : 1'b0), grp[i]};
                load[i+1].last = 1'b0;
            end
            // zero length ends the message on the only length byte
            load[1].last = len_zero;
            load_cnt = CNT_W'(2) + CNT_W'(cont[0]) + CNT_W'(cont[1]) + CNT_W'(cont[2]);
            bytes_remaining_next = payload_length;
            message_open_next    = !len_zero;
        end
        else if (pay_ok)
        begin
            load[0].data         = data_byte;
            load[0].last         = pay_final;
            load_cnt             = CNT_W'(1);
            bytes_remaining_next = bytes_remaining_reg - LEN_W'(1);
            message_open_next    = !pay_final;
        end
        else
        begin
            // stray payload: dropped
            message_open_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        pend_cnt_next = pend_cnt_reg;

        if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                pend_next[i] = pend_reg[i+1];
            end
            pend_cnt_next = pend_cnt_reg - CNT_W'(1);
        end

        if (accept)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                pend_next[i] = load[i];
            end
            pend_cnt_next = load_cnt;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg[0];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= '0;
            message_open_reg    <= 1'b0;
            pend_cnt_reg        <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                bytes_remaining_reg <= bytes_remaining_next;
                message_open_reg    <= message_open_next;
            end
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg.data;
    assign last      = out_reg.last;

endmodule

[design/tmf_checker.sv]
// Port-level checks for the message framer, bound to the top level.
module tmf_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        last
);
    import tmf_pkg::*;

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output byte changed while stalled");

    // a header expands to at least two bytes, so input closes behind it
    a_hdr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_HEADER |=> !in_ready)
        else $error("input ready right after a header");

    // an accepted header is followed by out_valid, after the result buffer and output register
    a_hdr_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_HEADER |=> ##1 out_valid)
        else $error("header produced no output");

endmodule

bind tts_message_framer_core tmf_port_checks u_tmf_checker (.*);
